// ===== sv/ipv4p_pkg.sv =====
// Package for the IPv4 dotted address parser: transaction payload types,
// parser phase and radix codes, and the field limits used during assembly.
// No dependencies.
package ipv4p_pkg;

   // Input transaction: one character of the string
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic        valid_res;
      logic [31:0] address;
   } rsp_type;

   // End-of-string snapshot passed from the parser to assembly
   typedef struct packed {
      logic             ok;
      logic [1:0]       count;
      logic [31:0]      number;
      logic [2:0][31:0] parts;
   } snap_type;

   localparam logic [2:0] PH_START  = 3'd0;
   localparam logic [2:0] PH_ZERO   = 3'd1;
   localparam logic [2:0] PH_DIGITS = 3'd2;
   localparam logic [2:0] PH_DONE   = 3'd3;
   localparam logic [2:0] PH_FAIL   = 3'd4;

   localparam logic [1:0] RDX_DEC = 2'd0;
   localparam logic [1:0] RDX_OCT = 2'd1;
   localparam logic [1:0] RDX_HEX = 2'd2;

   localparam logic [31:0] LIMIT_24 = 32'h00FF_FFFF;
   localparam logic [31:0] LIMIT_16 = 32'h0000_FFFF;
   localparam logic [31:0] LIMIT_8  = 32'h0000_00FF;
   localparam logic [31:0] ADDR_BAD = 32'hFFFF_FFFF;

endpackage

// ===== sv/ipv4p_parse.sv =====
// Character-level parser: phase, radix, running part value and stored parts.
// Depends on ipv4p_pkg.
module ipv4p_parse (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  ipv4p_pkg::req_type item,
   output ipv4p_pkg::snap_type snap
);
   import ipv4p_pkg::*;

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  radix_ff, radix_in;
   logic [31:0] number_ff, number_in;
   logic [1:0]  count_ff, count_in;
   logic [31:0] part_store_ff [3];

   logic        is_dec, is_ws, is_hex_letter, do_digits, store_en;
   logic [31:0] scaled;
   logic [7:0]  c;

   assign c = item.ch;

   always_comb begin
      is_dec        = c inside {[8'h30:8'h39]};
      is_ws         = c inside {8'h20, [8'h09:8'h0D]};
      is_hex_letter = c inside {[8'h61:8'h66], [8'h41:8'h46]};
      case (radix_ff)
         RDX_HEX: scaled = number_ff << 4;
         RDX_OCT: scaled = number_ff << 3;
         default: scaled = (number_ff << 3) + (number_ff << 1);
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      radix_in  = radix_ff;
      number_in = number_ff;
      count_in  = count_ff;
      store_en  = 1'b0;
      do_digits = 1'b0;
      case (phase_ff)
         PH_START: begin
            if (!is_dec) begin
               phase_in = PH_FAIL;
            end else if (c == 8'h30) begin
               number_in = '0;
               radix_in  = RDX_OCT;
               phase_in  = PH_ZERO;
            end else begin
               number_in = {28'd0, c[3:0]};
               radix_in  = RDX_DEC;
               phase_in  = PH_DIGITS;
            end
         end
         PH_ZERO: begin
            if (c == 8'h78 || c == 8'h58) begin
               radix_in = RDX_HEX;
               phase_in = PH_DIGITS;
            end else begin
               do_digits = 1'b1;
            end
         end
         PH_DIGITS: do_digits = 1'b1;
         default: ;
      endcase

      if (do_digits) begin
         phase_in = PH_DIGITS;
         if (is_dec) begin
            number_in = scaled + {28'd0, c[3:0]};
         end else if (radix_ff == RDX_HEX && is_hex_letter) begin
            // 'a'/'A' low nibble is 1, so +9 gives 10
            number_in = scaled | {28'd0, c[3:0] + 4'd9};
         end else if (c == 8'h2E) begin
            if (count_ff == 2'd3) begin
               phase_in = PH_FAIL;
            end else begin
               store_en = 1'b1;
               count_in = count_ff + 2'd1;
               phase_in = PH_START;
            end
         end else if (c == 8'h00 || is_ws) begin
            phase_in = PH_DONE;
         end else begin
            phase_in = PH_FAIL;
         end
      end
   end

   // End of string acts as a NUL: any part with at least one digit finishes cleanly
   always_comb begin
      snap.ok     = (phase_in == PH_ZERO) || (phase_in == PH_DIGITS) ||
                    (phase_in == PH_DONE);
      snap.count  = count_in;
      snap.number = number_in;
      snap.parts  = {part_store_ff[2], part_store_ff[1], part_store_ff[0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         radix_ff  <= RDX_DEC;
         number_ff <= '0;
         count_ff  <= '0;
      end else if (step) begin
         if (item.last) begin
            phase_ff  <= PH_START;
            radix_ff  <= RDX_DEC;
            number_ff <= '0;
            count_ff  <= '0;
         end else begin
            phase_ff  <= phase_in;
            radix_ff  <= radix_in;
            number_ff <= number_in;
            count_ff  <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && store_en) begin
         part_store_ff[count_ff] <= number_ff;
      end
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step && item.last |=> phase_ff == PH_START && count_ff == 2'd0 &&
                            radix_ff == RDX_DEC && number_ff == '0)
      else $error("parser state not cleared after last character");

   a_fail_sticks: assert property (@(posedge clock) disable iff (reset)
      step && !item.last && phase_ff == PH_FAIL |=> phase_ff == PH_FAIL)
      else $error("failed parse recovered before end of string");

   a_count_after_dot: assert property (@(posedge clock) disable iff (reset)
      step && !item.last && store_en |=> count_ff == $past(count_ff) + 2'd1)
      else $error("part count did not advance on separator");

endmodule

// ===== sv/ipv4p_assemble.sv =====
// Address assembly: range check of the final part, merge of earlier parts,
// byte swap to network order. Depends on ipv4p_pkg.
module ipv4p_assemble (
   input  ipv4p_pkg::snap_type snap,
   output ipv4p_pkg::rsp_type  rsp
);
   import ipv4p_pkg::*;

   logic [31:0] v;
   logic        part_fits;

   always_comb begin
      v         = snap.number;
      part_fits = 1'b1;
      case (snap.count)
         2'd0: ;
         2'd1: begin
            part_fits = snap.number <= LIMIT_24;
            v = snap.number | (snap.parts[0] << 24);
         end
         2'd2: begin
            part_fits = snap.number <= LIMIT_16;
            v = snap.number | (snap.parts[0] << 24) | (snap.parts[1] << 16);
         end
         default: begin
            part_fits = snap.number <= LIMIT_8;
            v = snap.number | (snap.parts[0] << 24) | (snap.parts[1] << 16) |
                (snap.parts[2] << 8);
         end
      endcase

      rsp.valid_res = snap.ok && part_fits;
      rsp.address   = rsp.valid_res ? {v[7:0], v[15:8], v[23:16], v[31:24]} : ADDR_BAD;
   end

endmodule

// ===== sv/ipv4_dotted_address_parser_core.sv =====
// IPv4 dotted address parser, top level.
// Depends on ipv4p_pkg, ipv4p_parse and ipv4p_assemble.
//
// Usage:
//   req channel: one ASCII character per transaction (req_data.ch), with
//   req_data.last set on the final character of the string. Characters with
//   last clear produce nothing. The transaction carrying last produces
//   exactly one rsp transaction: rsp_data.valid_res and rsp_data.address
//   (network byte order, all ones when the string does not parse).
//   Accepted forms are a, a.b, a.b.c and a.b.c.d with decimal, octal (leading
//   0) or hex (0x) parts; NUL or whitespace ends the parse early.
//   Throughput: one character per cycle, including back-to-back strings,
//   while the result side keeps up. The last character passes through the
//   input register, end-of-string stage and result register to rsp_valid.
//   The result register and a one-entry end-of-string stage decouple the
//   sides: while rsp_ready is low, characters keep flowing until both hold a
//   finished string; the next last character then waits in the input
//   register and req_ready drops.
//   Reset (synchronous) empties the pipeline and returns the parser to the
//   start of a string.
module ipv4_dotted_address_parser_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ipv4p_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ipv4p_pkg::rsp_type rsp_data
);
   import ipv4p_pkg::*;

   req_type  req_ff, req_in;
   logic     req_valid_ff, req_valid_in;
   snap_type snap_ff, snap_in, snap;
   logic     snap_valid_ff, snap_valid_in;
   rsp_type  rsp_ff, rsp_in, assembled;
   logic     rsp_valid_ff, rsp_valid_in;

   logic rsp_free, snap_move, snap_free, step;

   ipv4p_parse u_parse (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (req_ff),
      .snap  (snap)
   );

   ipv4p_assemble u_assemble (
      .snap (snap_ff),
      .rsp  (assembled)
   );

   always_comb begin
      rsp_free  = !rsp_valid_ff || rsp_ready;
      snap_move = snap_valid_ff && rsp_free;
      snap_free = !snap_valid_ff || snap_move;
      step      = req_valid_ff && (!req_ff.last || snap_free);
      req_ready = !req_valid_ff || step;

      req_in       = (req_valid && req_ready) ? req_data : req_ff;
      req_valid_in = req_ready ? req_valid : req_valid_ff;

      snap_in       = snap_ff;
      snap_valid_in = snap_valid_ff;
      if (step && req_ff.last) begin
         snap_in       = snap;
         snap_valid_in = 1'b1;
      end else if (snap_move) begin
         snap_valid_in = 1'b0;
      end

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (snap_move) begin
         rsp_in       = assembled;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         snap_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         req_valid_ff  <= req_valid_in;
         snap_valid_ff <= snap_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      snap_ff <= snap_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid_ff && !snap_valid_ff && !req_valid_ff)
      else $error("pipeline not empty after reset");

   a_bad_is_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.valid_res |-> rsp_ff.address == ADDR_BAD)
      else $error("invalid result without all-ones address");

   a_snap_held: assert property (@(posedge clock) disable iff (reset)
      snap_valid_ff && !rsp_free |=> snap_valid_ff && $stable(snap_ff))
      else $error("pending string result lost while output stalled");

   a_last_waits: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && req_ff.last && !snap_free |-> !step && !req_ready)
      else $error("last character consumed with no room for its result");

endmodule

// ===== bench/tb_top.sv =====
// Testbench for ipv4_dotted_address_parser_core: character strings in, checked addresses out.
// Depends on ipv4p_pkg and the core RTL. It predicts each result with its own parser and
// compares every result transaction, with random idling and stalls on both channels.
`timescale 1ns / 100ps

module tb_top;
   import ipv4p_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 20;

   logic    clock;
   logic    reset;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   ipv4_dotted_address_parser_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   req_type     char_q[$];
   rsp_type     parsed_addr_q[$];
   logic [7:0]  text[$];
   int          errors = 0;
   int          drain_at = -1;

   // predictor state
   logic [2:0]  pr_phase;
   logic [1:0]  pr_radix;
   logic [31:0] pr_value;
   logic [31:0] pr_parts [3];
   logic [1:0]  pr_count;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   //-------------------------------------------------------------------------
   // Parser prediction
   //-------------------------------------------------------------------------
   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_space(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function void clear_parser();
      pr_phase = PH_START;
      pr_radix = RDX_DEC;
      pr_value = '0;
      pr_count = '0;
      foreach (pr_parts[i]) pr_parts[i] = '0;
   endfunction

   function void take_digit(logic [7:0] c);
      logic [31:0] base;
      base = (pr_radix == RDX_HEX) ? 32'd16 : (pr_radix == RDX_OCT) ? 32'd8 : 32'd10;
      if (is_digit(c))
         pr_value = pr_value * base + 32'(c - 8'h30);
      else if (pr_radix == RDX_HEX && c >= "a" && c <= "f")
         pr_value = (pr_value << 4) | 32'(c - 8'h57);
      else if (pr_radix == RDX_HEX && c >= "A" && c <= "F")
         pr_value = (pr_value << 4) | 32'(c - 8'h37);
      else if (c == ".") begin
         if (pr_count == 2'd3)
            pr_phase = PH_FAIL;   // a fifth part
         else begin
            pr_parts[pr_count] = pr_value;
            pr_count = pr_count + 2'd1;
            pr_phase = PH_START;
         end
      end else if (c == 8'h00 || is_space(c))
         pr_phase = PH_DONE;
      else
         pr_phase = PH_FAIL;
   endfunction

   function void parse_char(logic [7:0] c);
      case (pr_phase)
         PH_START: begin
            if (!is_digit(c))
               pr_phase = PH_FAIL;
            else if (c == "0") begin
               pr_value = '0;
               pr_radix = RDX_OCT;
               pr_phase = PH_ZERO;
            end else begin
               pr_value = 32'(c - 8'h30);
               pr_radix = RDX_DEC;
               pr_phase = PH_DIGITS;
            end
         end
         PH_ZERO: begin
            if (c == "x" || c == "X") begin
               pr_radix = RDX_HEX;
               pr_phase = PH_DIGITS;
            end else begin
               pr_phase = PH_DIGITS;
               take_digit(c);
            end
         end
         PH_DIGITS: take_digit(c);
         default: ;
      endcase
   endfunction

   // End of string acts as a NUL; then assemble and range-check the final part.
   function void finish_string();
      logic [31:0] v;
      rsp_type     res;
      bit          ok;
      parse_char(8'h00);
      v  = pr_value;
      ok = (pr_phase == PH_DONE);
      case (pr_count)
         2'd0: ;
         2'd1: begin
            if (v > LIMIT_24) ok = 1'b0;
            v = v | (pr_parts[0] << 24);
         end
         2'd2: begin
            if (v > LIMIT_16) ok = 1'b0;
            v = v | (pr_parts[0] << 24) | (pr_parts[1] << 16);
         end
         default: begin
            if (v > LIMIT_8) ok = 1'b0;
            v = v | (pr_parts[0] << 24) | (pr_parts[1] << 16) | (pr_parts[2] << 8);
         end
      endcase
      res.valid_res = ok;
      res.address   = ok ? {v[7:0], v[15:8], v[23:16], v[31:24]} : ADDR_BAD;
      parsed_addr_q.push_back(res);
      clear_parser();
   endfunction

   //-------------------------------------------------------------------------
   // String generation
   //-------------------------------------------------------------------------
   function void push_text(string s, bit mix_case);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s.getc(i);
         if (mix_case && c >= "a" && c <= "f" && $urandom_range(1)) c = c - 8'h20;
         text.push_back(c);
      end
   endfunction

   function void emit_string();
      req_type item;
      foreach (text[i]) begin
         item.ch   = text[i];
         item.last = (i == text.size() - 1);
         char_q.push_back(item);
      end
      text.delete();
   endfunction

   function automatic logic [31:0] pick_value(logic [31:0] lim);
      case ($urandom_range(9))
         0: return '0;
         1: return lim;
         2: return lim + 32'd1;
         3: return $urandom;
         default: return $urandom_range(lim);
      endcase
   endfunction

   function void add_part(logic [31:0] v);
      int n;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: push_text($sformatf("%0d", v), 1'b0);
         5, 6: push_text({"0", $sformatf("%0o", v)}, 1'b0);
         7, 8: push_text({($urandom_range(1) ? "0x" : "0X"), $sformatf("%0h", v)}, 1'b1);
         default: begin
            case ($urandom_range(2))
               0: push_text($urandom_range(1) ? "0x" : "0X", 1'b0);
               1: begin
                  // octal part that may carry the digits 8 and 9
                  text.push_back("0");
                  n = $urandom_range(6, 1);
                  repeat (n) text.push_back(8'(8'h30 + $urandom_range(9)));
               end
               default: begin
                  // long decimal run that wraps past 32 bits
                  text.push_back(8'(8'h31 + $urandom_range(8)));
                  n = $urandom_range(14, 10);
                  repeat (n) text.push_back(8'(8'h30 + $urandom_range(9)));
               end
            endcase
         end
      endcase
   endfunction

   function void add_random_string();
      int          nparts;
      int          idx;
      int          n;
      logic [31:0] lim;
      logic [7:0]  stops [7];
      stops = '{8'h00, 8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
      nparts = ($urandom_range(14) == 0) ? 5 : $urandom_range(4, 1);
      for (int p = 0; p < nparts; p++) begin
         if (p != 0) text.push_back(".");
         if (p != nparts - 1)
            lim = LIMIT_8;
         else
            case (nparts)
               1: lim = ADDR_BAD;
               2: lim = LIMIT_24;
               3: lim = LIMIT_16;
               default: lim = LIMIT_8;
            endcase
         add_part(pick_value(lim));
      end
      idx = $urandom_range(text.size() - 1);
      case ($urandom_range(19))
         0, 1: text[idx] = 8'($urandom_range(255));
         2: if (text.size() > 1) text.delete(idx);
         3: text.push_back(".");
         4: text.insert(idx, 8'($urandom_range(255)));
         5: begin
            text.delete();
            n = $urandom_range(6, 1);
            repeat (n) text.push_back(8'($urandom_range(255)));
         end
         default: ;
      endcase
      // terminator followed by characters that must be ignored
      if ($urandom_range(3) == 0) begin
         text.push_back(stops[$urandom_range(6)]);
         n = $urandom_range(4);
         repeat (n) text.push_back(8'($urandom_range(255)));
      end
      emit_string();
   endfunction

   //-------------------------------------------------------------------------
   // Driver: offers characters, updates the predictor on each transaction
   //-------------------------------------------------------------------------
   int sent_cnt = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         sent_cnt  = 0;
         clear_parser();
      end else begin
         if (req_valid && req_ready) begin
            parse_char(req_data.ch);
            if (req_data.last) finish_string();
            sent_cnt++;
         end
         if (!req_valid || req_ready) begin
            if (char_q.size() != 0
                && !(sent_cnt == drain_at && parsed_addr_q.size() != 0)
                && ((sent_cnt >= 250 && sent_cnt < 450) || $urandom_range(99) >= 38)) begin
               req_valid <= 1'b1;
               req_data  <= char_q.pop_front();
            end else
               req_valid <= 1'b0;
         end
      end
   end

   //-------------------------------------------------------------------------
   // Monitor: accepts results and compares them with the predicted addresses
   //-------------------------------------------------------------------------
   int rsp_cnt   = 0;
   int hold_left = 0;
   bit held      = 1'b0;

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (parsed_addr_q.size() == 0) begin
               $error("unexpected result: valid_res %0b address %h",
                      rsp_data.valid_res, rsp_data.address);
               errors++;
            end else begin
               want = parsed_addr_q.pop_front();
               if (rsp_data.valid_res !== want.valid_res) begin
                  $error("valid_res: expected %0b, actual %0b",
                         want.valid_res, rsp_data.valid_res);
                  errors++;
               end
               if (rsp_data.address !== want.address) begin
                  $error("address: expected %h, actual %h", want.address, rsp_data.address);
                  errors++;
               end
            end
            rsp_cnt++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!held && rsp_cnt >= 15) begin
            // long back-pressure so the core fills and stalls its input
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else
            rsp_ready <= (rsp_cnt >= 60 && rsp_cnt < 80) || $urandom_range(99) >= 38;
      end
   end

   //-------------------------------------------------------------------------
   // Watchdog
   //-------------------------------------------------------------------------
   int stall_cnt = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cnt = 0;
      else begin
         stall_cnt++;
         if (stall_cnt >= STALL_LIMIT) begin
            $display("ipv4_dotted_address_parser_core: mismatch");
            $finish;
         end
      end
   end

   //-------------------------------------------------------------------------
   // Stimulus and end of run
   //-------------------------------------------------------------------------
   initial begin
      // directed: hex and octal with 8/9 (a.b), range limit, fifth part,
      // NUL terminator with ignored 0xFF, lone dot
      push_text("0Xf.0389", 1'b0);
      emit_string();
      push_text("0.0.0.256", 1'b0);
      emit_string();
      push_text("1.2.3.4.", 1'b0);
      emit_string();
      push_text("7", 1'b0);
      text.push_back(8'h00);
      text.push_back(8'hFF);
      emit_string();
      push_text(".", 1'b0);
      emit_string();

      while (char_q.size() < 1040) begin
         if (drain_at < 0 && char_q.size() >= 600) drain_at = char_q.size();
         add_random_string();
      end

      @(negedge reset);
      while (char_q.size() != 0 || req_valid || parsed_addr_q.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (errors == 0 && parsed_addr_q.size() == 0)
         $display("ipv4_dotted_address_parser_core: match");
      else
         $display("ipv4_dotted_address_parser_core: mismatch");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/ipv4p_pkg.sv
sv/ipv4p_parse.sv
sv/ipv4p_assemble.sv
sv/ipv4_dotted_address_parser_core.sv
bench/tb_top.sv
